[rtl/tpf_pkg.sv]
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants for the thyristor phase firing block.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int LEVEL_W = 15;
  localparam int TICK_W  = 16;
  localparam int ACC_W   = 19;
  localparam int CFG_IDX_W = 8;

  localparam logic [TICK_W-1:0] MAX_DELAY_RST   = 16'd23000;
  localparam logic [TICK_W-1:0] PULSE_WIDTH_RST = 16'd3000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 8'd1;

  // floor(x/10) = (x * 838861) >> 23, exact for x below 2**22
  localparam int RECIP_W = 20;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 20'd838861;
  localparam int DIV10_SHIFT = 23;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_FIRE = 2'd2;

  typedef struct packed {
    logic [1:0]        phase;
    logic [TICK_W-1:0] count;
    logic [TICK_W-1:0] delay;
  } seq_status_t;

endpackage

[rtl/tpf_if.sv]
// ----------------------------------------------------------------------------
// tpf_if
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface tpf_in_if import tpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               tick;
  logic               zero_pos;
  logic               zero_neg;
  logic               sample_valid;
  logic [LEVEL_W-1:0] pot_sample;

  modport source (output valid, tick, zero_pos, zero_neg, sample_valid, pot_sample,
                  input ready);
  modport sink   (input valid, tick, zero_pos, zero_neg, sample_valid, pot_sample,
                  output ready);
endinterface

interface tpf_out_if import tpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              gate_pos;
  logic              gate_neg;
  logic [TICK_W-1:0] firing_delay;

  modport source (output valid, gate_pos, gate_neg, firing_delay, input ready);
  modport sink   (input valid, gate_pos, gate_neg, firing_delay, output ready);
endinterface

interface tpf_cfg_if import tpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tpf_filter.sv]
// ----------------------------------------------------------------------------
// tpf_filter
// Potentiometer low-pass filter, level = floor((9*level + sample)/10),
// clamped to the maximum firing delay.
// ----------------------------------------------------------------------------
module tpf_filter import tpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               sample_valid,
  input  logic [LEVEL_W-1:0] sample,
  input  logic [TICK_W-1:0]  max_delay,
  output logic [LEVEL_W-1:0] level_nxt
);

  logic [LEVEL_W-1:0]         level_r;
  logic [ACC_W-1:0]           acc;
  logic [ACC_W+RECIP_W-1:0]   prod;
  logic [LEVEL_W-1:0]         filt;

  always_comb begin
    acc  = ACC_W'(level_r) * ACC_W'(9) + ACC_W'(sample);
    prod = (ACC_W+RECIP_W)'(acc) * (ACC_W+RECIP_W)'(DIV10_RECIP);
    filt = sample_valid ? prod[DIV10_SHIFT +: LEVEL_W] : level_r;
    if ({1'b0, filt} > max_delay) begin
      level_nxt = max_delay[LEVEL_W-1:0];
    end else begin
      level_nxt = filt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (en) begin
      level_r <= level_nxt;
    end
  end

endmodule

[rtl/tpf_seq.sv]
// ----------------------------------------------------------------------------
// tpf_seq
// Half-wave firing sequencer: latch delay on crossing, count ticks, then
// hold the gate for the pulse width.
// ----------------------------------------------------------------------------
module tpf_seq import tpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               crossing,
  input  logic               tick,
  input  logic [LEVEL_W-1:0] new_delay,
  input  logic [TICK_W-1:0]  pulse_width,
  output logic               fire_nxt,
  output seq_status_t        status
);

  logic [1:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic [TICK_W-1:0] delay_r, delay_nxt;
  logic [TICK_W-1:0] count_inc;
  logic [1:0]        fire_ph;

  always_comb begin
    count_inc = count_r + TICK_W'(1);
    fire_ph   = (pulse_width == '0) ? PH_IDLE : PH_FIRE;
    phase_nxt = phase_r;
    count_nxt = count_r;
    delay_nxt = delay_r;
    unique case (phase_r)
      PH_WAIT: begin
        if (tick) begin
          if (count_inc >= delay_r) begin
            count_nxt = '0;
            phase_nxt = fire_ph;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      PH_FIRE: begin
        if (tick) begin
          if (count_inc >= pulse_width) begin
            count_nxt = '0;
            phase_nxt = PH_IDLE;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (crossing) begin
          delay_nxt = TICK_W'(new_delay);
          count_nxt = '0;
          phase_nxt = (new_delay == '0) ? fire_ph : PH_WAIT;
        end
      end
    endcase
    fire_nxt = (phase_nxt == PH_FIRE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      delay_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      delay_r <= delay_nxt;
    end
  end

  assign status = '{phase: phase_r, count: count_r, delay: delay_r};

endmodule

[rtl/thyristor_phase_firing.sv]
// ----------------------------------------------------------------------------
// thyristor_phase_firing
// Phase-angle firing control for a two-pulse thyristor bridge, manual mode.
// Throughput: one word per cycle unless the result side stalls, set by the
// combinational filter and sequencer update between the input register
// and the result register.
// Reset: synchronous, clears level and sequencers, loads default registers.
// ----------------------------------------------------------------------------
module thyristor_phase_firing import tpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  tpf_in_if.sink  in_ch,
  tpf_out_if.source out_ch,
  tpf_cfg_if.sink cfg_ch
);

  logic [TICK_W-1:0] max_delay_r;
  logic [TICK_W-1:0] pulse_width_r;

  logic               s1_valid_r;
  logic               s1_tick_r;
  logic               s1_zpos_r;
  logic               s1_zneg_r;
  logic               s1_sval_r;
  logic [LEVEL_W-1:0] s1_sample_r;

  logic               out_valid_r;
  logic               gate_pos_r;
  logic               gate_neg_r;
  logic [TICK_W-1:0]  delay_out_r;

  logic               adv;
  logic               upd;
  logic [LEVEL_W-1:0] level_nxt;
  logic               pos_fire, neg_fire;
  seq_status_t        pos_st, neg_st;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r   <= MAX_DELAY_RST;
      pulse_width_r <= PULSE_WIDTH_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_MAX_DELAY) begin
        max_delay_r <= cfg_ch.data;
      end
      if (cfg_ch.index == CFG_PULSE_WIDTH) begin
        pulse_width_r <= cfg_ch.data;
      end
    end
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign upd         = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_tick_r   <= in_ch.tick;
      s1_zpos_r   <= in_ch.zero_pos;
      s1_zneg_r   <= in_ch.zero_neg;
      s1_sval_r   <= in_ch.sample_valid;
      s1_sample_r <= in_ch.pot_sample;
    end
  end

  tpf_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (upd),
    .sample_valid (s1_sval_r),
    .sample       (s1_sample_r),
    .max_delay    (max_delay_r),
    .level_nxt    (level_nxt)
  );

  tpf_seq u_seq_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (upd),
    .crossing    (s1_zpos_r),
    .tick        (s1_tick_r),
    .new_delay   (level_nxt),
    .pulse_width (pulse_width_r),
    .fire_nxt    (pos_fire),
    .status      (pos_st)
  );

  tpf_seq u_seq_neg (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (upd),
    .crossing    (s1_zneg_r),
    .tick        (s1_tick_r),
    .new_delay   (level_nxt),
    .pulse_width (pulse_width_r),
    .fire_nxt    (neg_fire),
    .status      (neg_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      gate_pos_r  <= pos_fire;
      gate_neg_r  <= neg_fire;
      delay_out_r <= TICK_W'(level_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.gate_pos     = gate_pos_r;
  assign out_ch.gate_neg     = gate_neg_r;
  assign out_ch.firing_delay = delay_out_r;

  a_pos_wait_below: assert property (@(posedge clk) disable iff (!rst_n)
    pos_st.phase == PH_WAIT |-> pos_st.count < pos_st.delay)
    else $error("positive sequencer count reached delay while waiting");

  a_neg_wait_below: assert property (@(posedge clk) disable iff (!rst_n)
    neg_st.phase == PH_WAIT |-> neg_st.count < neg_st.delay)
    else $error("negative sequencer count reached delay while waiting");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("stalled input word dropped");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_valid_r)
    else $error("processed word produced no result word");

endmodule

[tb/firing_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// firing_checker
// Watches the input, result and register channels of the firing block,
// predicts the gate outputs and firing delay for every accepted input word
// and compares each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module firing_checker import tpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tpf_in_if    in_mon,
  tpf_out_if   out_mon,
  tpf_cfg_if   cfg_mon,
  output int   mismatches,
  output int   in_flight
);

  localparam logic [1:0] PH_SPARE = 2'd3;
  localparam int HALF_POS = 0;
  localparam int HALF_NEG = 1;

  typedef struct packed {
    logic              gate_pos;
    logic              gate_neg;
    logic [TICK_W-1:0] firing_delay;
  } gate_word_t;

  gate_word_t         gate_queue[$];
  logic [TICK_W-1:0]  delay_cap;
  logic [TICK_W-1:0]  pulse_len;
  logic [LEVEL_W-1:0] level;
  logic [1:0]         phase[2];
  logic [TICK_W-1:0]  count[2];
  logic [TICK_W-1:0]  latched_delay[2];
  int                 error_total = 0;
  int                 pending_words = 0;

  assign mismatches = error_total;
  assign in_flight  = pending_words;

  function automatic logic [1:0] fire_or_idle();
    return (pulse_len == '0) ? PH_IDLE : PH_FIRE;
  endfunction

  function automatic void advance_half(input int h, input logic crossing, input logic tick_in);
    logic [1:0] ph;
    ph = phase[h];
    if (ph == PH_SPARE) ph = PH_IDLE;
    if (ph == PH_IDLE) begin
      if (crossing) begin
        latched_delay[h] = TICK_W'(level);
        count[h] = '0;
        ph = (level == '0) ? fire_or_idle() : PH_WAIT;
      end
    end else if (tick_in) begin
      count[h] = count[h] + 1'b1;
      if (ph == PH_WAIT) begin
        if (count[h] >= latched_delay[h]) begin
          count[h] = '0;
          ph = fire_or_idle();
        end
      end else if (count[h] >= pulse_len) begin
        count[h] = '0;
        ph = PH_IDLE;
      end
    end
    phase[h] = ph;
  endfunction

  function automatic gate_word_t predict_gates(input logic tick_in, input logic zp,
                                               input logic zn, input logic sv,
                                               input logic [LEVEL_W-1:0] sample);
    logic [ACC_W-1:0] acc;
    gate_word_t       w;
    if (sv) begin
      acc = ACC_W'(level) * ACC_W'(9) + ACC_W'(sample);
      level = LEVEL_W'(acc / ACC_W'(10));
    end
    if (TICK_W'(level) > delay_cap) level = delay_cap[LEVEL_W-1:0];
    advance_half(HALF_POS, zp, tick_in);
    advance_half(HALF_NEG, zn, tick_in);
    w.gate_pos     = (phase[HALF_POS] == PH_FIRE);
    w.gate_neg     = (phase[HALF_NEG] == PH_FIRE);
    w.firing_delay = TICK_W'(level);
    return w;
  endfunction

  always @(posedge clk) begin
    gate_word_t want;
    if (!rst_n) begin
      delay_cap = MAX_DELAY_RST;
      pulse_len = PULSE_WIDTH_RST;
      level = '0;
      for (int h = 0; h < 2; h++) begin
        phase[h] = PH_IDLE;
        count[h] = '0;
        latched_delay[h] = '0;
      end
      gate_queue.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (gate_queue.size() == 0) begin
          $error("unexpected result word: gate_pos %0d gate_neg %0d firing_delay %0d",
                 out_mon.gate_pos, out_mon.gate_neg, out_mon.firing_delay);
          error_total++;
        end else begin
          want = gate_queue.pop_front();
          if (out_mon.gate_pos !== want.gate_pos) begin
            $error("gate_pos: expected %0d, actual %0d", want.gate_pos, out_mon.gate_pos);
            error_total++;
          end
          if (out_mon.gate_neg !== want.gate_neg) begin
            $error("gate_neg: expected %0d, actual %0d", want.gate_neg, out_mon.gate_neg);
            error_total++;
          end
          if (out_mon.firing_delay !== want.firing_delay) begin
            $error("firing_delay: expected %0d, actual %0d",
                   want.firing_delay, out_mon.firing_delay);
            error_total++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MAX_DELAY:   delay_cap = cfg_mon.data;
          CFG_PULSE_WIDTH: pulse_len = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        gate_queue.push_back(predict_gates(in_mon.tick, in_mon.zero_pos, in_mon.zero_neg,
                                           in_mon.sample_valid, in_mon.pot_sample));
      end
    end
    pending_words <= gate_queue.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the firing block with directed and random input words under several
// delay clamp and pulse width settings, with random gaps on the input and
// random stalls on the result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import tpf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'd2;
  localparam int NUM_PHASES = 6;
  localparam logic [TICK_W-1:0] DELAY_CAPS [NUM_PHASES] =
    '{16'd0, 16'd4, 16'hFFFF, 16'd12, 16'd1, 16'd30};
  localparam logic [TICK_W-1:0] PULSE_LENS [NUM_PHASES] =
    '{16'd0, 16'd3, 16'hFFFF, 16'd6, 16'd1, 16'd10};
  localparam int PHASE_WORDS [NUM_PHASES] = '{60, 70, 40, 70, 70, 90};

  logic clk;
  logic rst_n;
  bit   quiet_tail;
  int   mismatches;
  int   in_flight;

  tpf_in_if  in_bus();
  tpf_out_if out_bus();
  tpf_cfg_if cfg_bus();

  thyristor_phase_firing dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  firing_checker gate_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[thyristor_phase_firing] ERROR");
    $finish;
  end

  initial begin
    int  hold;
    bit  stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_tail) begin
        out_bus.ready = 1'b1;
      end else begin
        stall = ($urandom_range(0, 3) == 0);
        out_bus.ready = !stall;
        hold = stall ? $urandom_range(1, 18) : $urandom_range(1, 60);
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  task automatic send_word(input logic t, input logic zp, input logic zn, input logic sv,
                           input logic [LEVEL_W-1:0] s);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_bus.valid        = 1'b1;
    in_bus.tick         = t;
    in_bus.zero_pos     = zp;
    in_bus.zero_neg     = zn;
    in_bus.sample_valid = sv;
    in_bus.pot_sample   = s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [LEVEL_W-1:0] s;
    int                 pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)      s = LEVEL_W'($urandom_range(0, 40));
    else if (pick < 8) s = LEVEL_W'($urandom);
    else if (pick == 8) s = '1;
    else               s = '0;
    send_word($urandom_range(0, 9) < 7, $urandom_range(0, 7) == 0,
              $urandom_range(0, 7) == 0, $urandom_range(0, 2) == 0, s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    quiet_tail = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.tick = 1'b0;
    in_bus.zero_pos = 1'b0;
    in_bus.zero_neg = 1'b0;
    in_bus.sample_valid = 1'b0;
    in_bus.pot_sample = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_MAX_DELAY;
    cfg_bus.data = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // zero delay start, start-cycle tick, busy crossings, rising level into the clamp
    send_word(1'b0, 1'b0, 1'b0, 1'b0, '0);
    send_word(1'b1, 1'b1, 1'b0, 1'b0, '0);
    send_word(1'b1, 1'b1, 1'b0, 1'b0, '0);
    send_word(1'b0, 1'b0, 1'b0, 1'b1, '1);
    send_word(1'b1, 1'b0, 1'b1, 1'b1, '1);
    send_word(1'b1, 1'b0, 1'b1, 1'b0, '0);
    repeat (10) send_word(1'b1, 1'b0, 1'b0, 1'b1, '1);
    send_word(1'b0, 1'b0, 1'b0, 1'b1, '0);
    send_word(1'b1, 1'b1, 1'b1, 1'b1, '1);
    send_word(1'b1, 1'b0, 1'b0, 1'b1, 15'h5555);
    send_word(1'b0, 1'b0, 1'b0, 1'b1, 15'h2AAA);

    // shorten a running pulse, clamp the stored level to zero
    drain();
    write_reg(CFG_PULSE_WIDTH, 16'd1);
    write_reg(CFG_MAX_DELAY, 16'd0);
    write_reg(CFG_NO_REG, 16'hFFFF);
    send_word(1'b1, 1'b0, 1'b0, 1'b0, '0);
    send_word(1'b1, 1'b0, 1'b0, 1'b0, '0);
    send_word(1'b0, 1'b1, 1'b1, 1'b0, '0);
    send_word(1'b1, 1'b0, 1'b0, 1'b0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_MAX_DELAY, DELAY_CAPS[p]);
      write_reg(CFG_PULSE_WIDTH, PULSE_LENS[p]);
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      repeat (PHASE_WORDS[p]) send_random_word();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[thyristor_phase_firing] OK");
    end else begin
      $display("[thyristor_phase_firing] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tpf_pkg.sv
rtl/tpf_if.sv
rtl/tpf_filter.sv
rtl/tpf_seq.sv
rtl/thyristor_phase_firing.sv
tb/firing_checker.sv
tb/testbench.sv
